[rtl/weighted_laplace_jacobi_sweep_defines.svh]
// Assertion macros used by the checker file.
`ifndef WEIGHTED_LAPLACE_JACOBI_SWEEP_DEFINES_SVH
`define WEIGHTED_LAPLACE_JACOBI_SWEEP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WLJS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define WLJS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wljs_pkg.sv]
// Types and constants of the weighted Laplace Jacobi sweep block.
`timescale 1ns / 1ps
package wljs_pkg;

  typedef struct packed {
    logic signed [31:0] cell_potential;
    logic [29:0]        cell_conductivity;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic signed [31:0] new_potential;
    logic               last_in_run;
    logic               sweep_done;
  } out_item_t;

  // Line store entry: conductivity over potential.
  typedef struct packed {
    logic [29:0]        cond;
    logic signed [31:0] pot;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_C,
    ST_RD_N,
    ST_RD_W,
    ST_RD_E,
    ST_CAP_E,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT
  } wljs_state_e;

  localparam logic       REG_GRID_SIZE       = 1'b0;
  localparam logic       REG_APPLIED_VOLTAGE = 1'b1;
  localparam logic [8:0] GRID_SIZE_RST       = 9'd256;
  localparam int         DIV_STEPS           = 32;

endpackage

[rtl/wljs_div.sv]
// Iterative signed 64 by unsigned 32 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wljs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic signed [31:0] quotient_o
);
  import wljs_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] lo_q, lo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;

  logic [63:0] mag;
  logic [32:0] rem2;
  logic        ge;

  // Magnitude of the dividend; the quotient always fits 32 bits
  assign mag  = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
  assign rem2 = {rem_q, lo_q[31]};
  assign ge   = rem2 >= {1'b0, dvs_q};

  // Shift in one dividend bit and subtract where it fits
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = mag[63:32];
      lo_d   = mag[31:0];
      dvs_d  = divisor_i;
      neg_d  = dividend_i[63];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem2 - {1'b0, dvs_q}) : rem2[31:0];
      lo_d  = {lo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // Apply the sign; a zero divisor gives zero
  assign done_o     = done_q;
  assign quotient_o = zero_q ? '0 : (neg_q ? -$signed(lo_q) : $signed(lo_q));

endmodule

[rtl/weighted_laplace_jacobi_sweep.sv]
// A top-row cell is committed on transfer and its results are loaded into the output
// register. An interior cell passes four line store reads and a capture, the multiply
// steps, the divider start, the 32-step divider and the output load. A new cell is taken
// only in the idle state, so the input stalls until every result of the current cell
// has been loaded.
// Reset clears counters, the delay cell and control; the line store is not cleared.
`timescale 1ns / 1ps
module weighted_laplace_jacobi_sweep #(
  parameter int MAX_GRID = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wljs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wljs_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import wljs_pkg::*;

  localparam int CW    = $clog2(MAX_GRID);
  localparam int NW    = CW + 1;
  localparam int DEPTH = 2 * MAX_GRID;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [AW-1:0] slot(input logic par, input logic [CW-1:0] col);
    return par ? AW'(MAX_GRID) + AW'(col) : AW'(col);
  endfunction

  wljs_state_e state_q, state_d;

  logic [8:0]         grid_size_q;
  logic signed [31:0] voltage_q;
  logic [CW-1:0]      row_q, col_q;
  entry_t             cur_q;
  entry_t             pend_q;
  logic [AW-1:0]      pend_slot_q;
  logic               pend_valid_q;

  entry_t             mem [DEPTH];
  entry_t             rd_q;
  logic               mem_we;
  logic [AW-1:0]      raddr;

  logic [29:0]        cc_q;
  logic [29:0]        nb_cond_q [4];
  logic signed [31:0] nb_pot_q [4];
  logic [2:0]         step_q;
  logic signed [62:0] prod_q;
  logic signed [63:0] acc_q;
  logic [31:0]        den_q;

  out_item_t          res_q [3];
  out_item_t          fill [3];
  logic [1:0]         res_cnt_q, fill_cnt;
  logic [1:0]         res_idx_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               accept, cfg_we, interior, commit, load;
  logic               last_col, last_row, div_done;
  logic signed [31:0] div_quot;
  logic [NW-1:0]      n_eff;
  logic [31:0]        gs32;
  logic [29:0]        w_sel;
  logic signed [31:0] p_sel;
  logic [30:0]        wsum;
  entry_t             cur_src;

  // Clamp the grid size to the supported range
  always_comb begin
    gs32 = 32'(grid_size_q);
    if (gs32 < 32'd3) begin
      n_eff = NW'(3);
    end else if (gs32 > 32'(MAX_GRID)) begin
      n_eff = NW'(MAX_GRID);
    end else begin
      n_eff = NW'(gs32);
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign cfg_we   = psel && penable && pwrite && pready;
  assign interior = (row_q >= CW'(2)) && (col_q >= CW'(2));
  assign last_col = (NW'(col_q) == n_eff - NW'(1));
  assign last_row = (NW'(row_q) == n_eff - NW'(1));
  assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign commit   = (state_q == ST_IDLE && accept && !interior) ||
                    (state_q == ST_DIV && div_done);
  assign cur_src  = (state_q == ST_IDLE) ? entry_t'({in_data_i.cell_conductivity,
                                                     in_data_i.cell_potential}) : cur_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (interior) begin
            state_d = ST_RD_C;
          end else if (row_q == '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_RD_C:      state_d = ST_RD_N;
      ST_RD_N:      state_d = ST_RD_W;
      ST_RD_W:      state_d = ST_RD_E;
      ST_RD_E:      state_d = ST_CAP_E;
      ST_CAP_E:     state_d = ST_MUL;
      ST_MUL:       if (step_q == 3'd4) state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV;
      ST_DIV:       if (div_done) state_d = ST_EMIT;
      ST_EMIT:      if (load && res_idx_q == res_cnt_q - 2'd1) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Read addresses and stall
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_we     = commit && pend_valid_q;
    case (state_q)
      ST_RD_C: raddr = slot(~row_q[0], col_q - CW'(1));
      ST_RD_N: raddr = slot(row_q[0], col_q - CW'(1));
      ST_RD_W: raddr = slot(~row_q[0], col_q - CW'(2));
      ST_RD_E: raddr = slot(~row_q[0], col_q);
      default: raddr = slot(~row_q[0], col_q);
    endcase
  end

  // Line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[pend_slot_q] <= pend_q;
    end
    rd_q <= mem[raddr];
  end

  // Weight and potential of the neighbor in turn: north, south, west, east
  always_comb begin
    case (step_q[1:0])
      2'd0:    wsum = {1'b0, cc_q} + {1'b0, nb_cond_q[0]};
      2'd1:    wsum = {1'b0, cc_q} + {1'b0, pend_q.cond};
      2'd2:    wsum = {1'b0, cc_q} + {1'b0, nb_cond_q[2]};
      default: wsum = {1'b0, cc_q} + {1'b0, nb_cond_q[3]};
    endcase
    w_sel = wsum[30:1];
    case (step_q[1:0])
      2'd0:    p_sel = nb_pot_q[0];
      2'd1:    p_sel = pend_q.pot;
      2'd2:    p_sel = nb_pot_q[2];
      default: p_sel = nb_pot_q[3];
    endcase
  end

  wljs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIV_START),
    .dividend_i (acc_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Build the results of the current cell
  always_comb begin
    int k;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      fill[i] = '0;
    end
    if (row_q == '0) begin
      fill[0] = '{out_row: 8'd0, out_col: 8'(col_q), new_potential: voltage_q,
                  last_in_run: 1'b0, sweep_done: 1'b0};
      fill[1] = '{out_row: 8'(n_eff - NW'(1)), out_col: 8'(col_q), new_potential: '0,
                  last_in_run: 1'b1, sweep_done: last_row && last_col};
      k = 2;
    end else if (interior) begin
      if (col_q == CW'(2)) begin
        fill[k] = '{out_row: 8'(row_q - CW'(1)), out_col: 8'd0, new_potential: div_quot,
                    last_in_run: 1'b0, sweep_done: 1'b0};
        k = k + 1;
      end
      fill[k] = '{out_row: 8'(row_q - CW'(1)), out_col: 8'(col_q - CW'(1)),
                  new_potential: div_quot, last_in_run: 1'b0, sweep_done: 1'b0};
      k = k + 1;
      if (last_col) begin
        fill[k] = '{out_row: 8'(row_q - CW'(1)), out_col: 8'(n_eff - NW'(1)),
                    new_potential: div_quot, last_in_run: 1'b0, sweep_done: 1'b0};
        k = k + 1;
      end
      fill[k-1].last_in_run = 1'b1;
      fill[k-1].sweep_done  = last_row && last_col;
    end
    fill_cnt = 2'(k);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      grid_size_q  <= GRID_SIZE_RST;
      voltage_q    <= '0;
      row_q        <= '0;
      col_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_idx_q    <= '0;
      res_cnt_q    <= '0;
      step_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (paddr[2])
          REG_GRID_SIZE: begin
            grid_size_q  <= pwdata[8:0];
            row_q        <= '0;
            col_q        <= '0;
            pend_valid_q <= 1'b0;
          end
          REG_APPLIED_VOLTAGE: voltage_q <= pwdata;
          default: ;
        endcase
      end else if (commit) begin
        // Retire the cell: advance the raster position and the delay cell
        res_idx_q <= '0;
        res_cnt_q <= fill_cnt;
        if (NW'(col_q) + NW'(1) >= n_eff) begin
          col_q <= '0;
          if (last_row) begin
            row_q        <= '0;
            pend_valid_q <= 1'b0;
          end else begin
            row_q        <= row_q + CW'(1);
            pend_valid_q <= 1'b1;
          end
        end else begin
          col_q        <= col_q + CW'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (state_q == ST_CAP_E) begin
        step_q <= '0;
      end else if (state_q == ST_MUL) begin
        step_q <= step_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
        res_idx_q   <= res_idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      cur_q <= cur_src;
    end
    if (commit) begin
      pend_q      <= cur_src;
      pend_slot_q <= slot(row_q[0], col_q);
      res_q       <= fill;
    end
    case (state_q)
      ST_RD_N:  cc_q <= rd_q.cond;
      ST_RD_W: begin
        nb_cond_q[0] <= rd_q.cond;
        nb_pot_q[0]  <= rd_q.pot;
      end
      ST_RD_E: begin
        nb_cond_q[2] <= rd_q.cond;
        nb_pot_q[2]  <= rd_q.pot;
      end
      ST_CAP_E: begin
        nb_cond_q[3] <= rd_q.cond;
        nb_pot_q[3]  <= rd_q.pot;
        acc_q        <= '0;
        den_q        <= '0;
      end
      ST_MUL: begin
        // Multiply one neighbor, accumulate the previous product
        if (step_q != 3'd4) begin
          prod_q <= $signed({1'b0, w_sel}) * p_sel;
          den_q  <= den_q + 32'(w_sel);
        end
        if (step_q != 3'd0) begin
          acc_q <= acc_q + 64'(prod_q);
        end
      end
      default: ;
    endcase
    if (load) begin
      out_q <= res_q[res_idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_GRID_SIZE) ? 32'(grid_size_q) : voltage_q;

endmodule

[rtl/wljs_checker.sv]
// Port-level checks of the sweep block and their binding.
`timescale 1ns / 1ps
`include "weighted_laplace_jacobi_sweep_defines.svh"
module wljs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input wljs_pkg::out_item_t out_data_o
);
  import wljs_pkg::*;

  `WLJS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `WLJS_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_data_o), "stalled result changed")
  `WLJS_ASSERT_NOW(a_done_last, out_valid_o && out_data_o.sweep_done, out_data_o.last_in_run, "sweep end not last of run")

endmodule

bind weighted_laplace_jacobi_sweep wljs_checker u_wljs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/tb.sv]
// Self-checking testbench for the weighted Laplace Jacobi sweep block.
`timescale 1ns / 1ps
module tb;
  import wljs_pkg::*;

  localparam int          GRID_MAX      = 256;
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          ITEM_TARGET   = 370;
  localparam logic [2:0]  ADDR_GRID     = {REG_GRID_SIZE, 2'b00};
  localparam logic [2:0]  ADDR_VOLTAGE  = {REG_APPLIED_VOLTAGE, 2'b00};
  localparam logic [29:0] COND_MAX      = 30'h3FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  weighted_laplace_jacobi_sweep u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk = ~clk;

  // Predictor state: grid setup, counters, line buffers and the delayed cell.
  logic [8:0]         size_reg = GRID_SIZE_RST;
  logic signed [31:0] voltage_reg = '0;
  int unsigned        row_cnt = 0;
  int unsigned        col_cnt = 0;
  entry_t             line_buf [2*GRID_MAX];
  entry_t             held_cell = '0;
  int unsigned        held_slot = 0;
  bit                 held_valid = 1'b0;
  out_item_t          potentials_due [$];

  int  error_count = 0;
  int  cells_sent = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  activity = 1'b0;

  function automatic int unsigned grid_used();
    if (size_reg < 3) return 3;
    if (size_reg > GRID_MAX) return GRID_MAX;
    return size_reg;
  endfunction

  function automatic void queue_potential(int unsigned r, int unsigned c, logic [31:0] v);
    out_item_t res;
    res = '0;
    res.out_row = r[7:0];
    res.out_col = c[7:0];
    res.new_potential = v;
    potentials_due.push_back(res);
  endfunction

  function automatic logic [31:0] weighted_mean(entry_t ctr, entry_t nb_n, entry_t nb_s,
                                               entry_t nb_w, entry_t nb_e);
    longint sc, wn, ws, ww, we, den, num;
    sc  = longint'(ctr.cond);
    wn  = (sc + longint'(nb_n.cond)) >> 1;
    ws  = (sc + longint'(nb_s.cond)) >> 1;
    ww  = (sc + longint'(nb_w.cond)) >> 1;
    we  = (sc + longint'(nb_e.cond)) >> 1;
    den = wn + ws + ww + we;
    if (den == 0) return '0;
    num = wn * longint'(nb_n.pot) + ws * longint'(nb_s.pot)
        + ww * longint'(nb_w.pot) + we * longint'(nb_e.pot);
    return 32'(num / den);
  endfunction

  // Advance the predictor by one accepted cell.
  function automatic void predict_sweep(in_item_t item);
    int unsigned n, r, c, mid, top, kc;
    int          k;
    entry_t      south;
    logic [31:0] inner;
    n = grid_used();
    r = row_cnt;
    c = col_cnt;
    k = 0;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
      held_valid = 1'b0;
    end
    if (r == 0) begin
      queue_potential(0, c, voltage_reg);
      queue_potential(n - 1, c, '0);
      k = 2;
    end else if (r >= 2 && c >= 2) begin
      mid = ((r - 1) & 1) * GRID_MAX;
      top = (r & 1) * GRID_MAX;
      kc = c - 1;
      south = held_valid ? held_cell : '0;
      inner = weighted_mean(line_buf[mid + kc], line_buf[top + kc], south,
                            line_buf[mid + kc - 1], line_buf[mid + kc + 1]);
      if (c == 2) begin
        queue_potential(r - 1, 0, inner);
        k++;
      end
      queue_potential(r - 1, kc, inner);
      k++;
      if (c == n - 1) begin
        queue_potential(r - 1, n - 1, inner);
        k++;
      end
    end
    if (held_valid) line_buf[held_slot % (2*GRID_MAX)] = held_cell;
    held_cell = '{cond: item.cell_conductivity, pot: item.cell_potential};
    held_slot = (r & 1) * GRID_MAX + c;
    held_valid = 1'b1;
    if (k > 0) begin
      potentials_due[potentials_due.size()-1].last_in_run = 1'b1;
      if (r == n - 1 && c == n - 1)
        potentials_due[potentials_due.size()-1].sweep_done = 1'b1;
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) begin
        r = 0;
        held_valid = 1'b0;
      end
    end
    row_cnt = r;
    col_cnt = c;
  endfunction

  // Write one register over the APB port and mirror it in the predictor.
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_GRID) begin
      size_reg = value[8:0];
      row_cnt = 0;
      col_cnt = 0;
      held_valid = 1'b0;
    end else begin
      voltage_reg = value;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Send one cell; the sender runs in bursts with random gaps between them.
  task automatic send_cell(in_item_t item);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    predict_sweep(item);
    cells_sent++;
  endtask

  // Drop valid and wait until every result is in and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    wait (potentials_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_cell();
    in_item_t item;
    case ($urandom_range(0, 7))
      0: item.cell_potential = 32'h7FFF_FFFF;
      1: item.cell_potential = 32'h8000_0000;
      2: item.cell_potential = '0;
      default: item.cell_potential = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: item.cell_conductivity = '0;
      1: item.cell_conductivity = COND_MAX;
      2: item.cell_conductivity = $urandom_range(0, 3);
      default: item.cell_conductivity = $urandom_range(0, 32'h3FFF_FFFF);
    endcase
    return item;
  endfunction

  task automatic send_random_cells(int count);
    repeat (count) send_cell(random_cell());
  endtask

  // Reset values: full-size grid, so the bottom row tag is 255.
  task automatic test_default_size();
    send_random_cells(12);
    drain();
  endtask

  // All conductivities zero: every weight sum is zero.
  task automatic test_zero_weight();
    in_item_t item;
    write_reg(ADDR_GRID, 32'd0);
    write_reg(ADDR_VOLTAGE, 32'h8000_0000);
    for (int i = 0; i < 9; i++) begin
      item.cell_potential = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      item.cell_conductivity = '0;
      send_cell(item);
    end
    drain();
  endtask

  // Extreme potentials, mostly at maximal conductivity, on the smallest grid.
  task automatic test_extremes();
    in_item_t item;
    write_reg(ADDR_GRID, 32'd1);
    write_reg(ADDR_VOLTAGE, 32'h7FFF_FFFF);
    for (int i = 0; i < 9; i++) begin
      item.cell_potential = (i == 4) ? 32'h0 : ((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      item.cell_conductivity = (i == 3) ? 30'h0 : COND_MAX;
      send_cell(item);
    end
    drain();
  endtask

  // Oversized grid value clamps to the largest grid.
  task automatic test_size_clamp();
    write_reg(ADDR_GRID, 32'h1FF);
    send_random_cells(6);
    drain();
  endtask

  // Rewrite the size mid-sweep, then run past the end into a new sweep.
  task automatic test_restart();
    write_reg(ADDR_GRID, 32'd5);
    send_random_cells(13);
    drain();
    write_reg(ADDR_GRID, 32'd4);
    send_random_cells(19);
    drain();
  endtask

  task automatic test_random_sweeps();
    int unsigned n;
    int          count;
    while (cells_sent < ITEM_TARGET) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(3, 7);
      write_reg(ADDR_GRID, n);
      if ($urandom_range(0, 2) == 0) write_reg(ADDR_VOLTAGE, $urandom);
      count = n * n;
      case ($urandom_range(0, 5))
        0: count = $urandom_range(1, n * n - 1);
        1: count = n * n + $urandom_range(1, 2 * n);
        default: ;
      endcase
      send_random_cells(count);
      drain();
    end
  endtask

  // Receiver stall pattern: switch between no stalls, light and heavy stalls.
  int stall_phase = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 2);
    end
    stall_phase--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each transfer on the result side with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_item;
    activity = 1'b0;
    if (rst_n && in_valid && !in_stall) activity = 1'b1;
    if (psel) activity = 1'b1;
    if (rst_n && out_valid && !out_stall) begin
      activity = 1'b1;
      if (potentials_due.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d potential %0d", $time,
                 out_data.out_row, out_data.out_col, out_data.new_potential);
        error_count++;
      end else begin
        exp_item = potentials_due.pop_front();
        if (out_data.out_row !== exp_item.out_row) begin
          $display("%0t: out_row expected %0d actual %0d", $time,
                   exp_item.out_row, out_data.out_row);
          error_count++;
        end
        if (out_data.out_col !== exp_item.out_col) begin
          $display("%0t: out_col expected %0d actual %0d", $time,
                   exp_item.out_col, out_data.out_col);
          error_count++;
        end
        if (out_data.new_potential !== exp_item.new_potential) begin
          $display("%0t: new_potential expected %0d actual %0d", $time,
                   exp_item.new_potential, out_data.new_potential);
          error_count++;
        end
        if (out_data.last_in_run !== exp_item.last_in_run) begin
          $display("%0t: last_in_run expected %0b actual %0b", $time,
                   exp_item.last_in_run, out_data.last_in_run);
          error_count++;
        end
        if (out_data.sweep_done !== exp_item.sweep_done) begin
          $display("%0t: sweep_done expected %0b actual %0b", $time,
                   exp_item.sweep_done, out_data.sweep_done);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (activity) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_size();
    test_zero_weight();
    test_extremes();
    test_size_clamp();
    test_restart();
    test_random_sweeps();
    if (error_count == 0 && potentials_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (potentials_due.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, potentials_due.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[weighted_laplace_jacobi_sweep.f]
+incdir+rtl
rtl/wljs_pkg.sv
rtl/wljs_div.sv
rtl/weighted_laplace_jacobi_sweep.sv
rtl/wljs_checker.sv
tb/tb.sv
